### rtl/blps_pkg.sv
`timescale 1ns / 1ps
package blps_pkg;

   // default geometry of the stepper
   localparam int COORD_BITS_DEFAULT = 12;
   localparam int BANK_BITS_DEFAULT  = 16;

   // fixed field widths
   localparam int DIM_W          = 12;
   localparam int COLOR_W        = 8;
   localparam int BANK_FIELD_W   = 6;
   localparam int OFFSET_FIELD_W = 16;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;

   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRAW_COLOR    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_XOR_MODE      = 2'd3;

   localparam logic [DIM_W-1:0] RESET_WIDTH  = 12'd640;
   localparam logic [DIM_W-1:0] RESET_HEIGHT = 12'd480;

   // item opcodes
   localparam logic OP_START   = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   // step direction codes (two's complement -1, 0, +1)
   localparam logic [1:0] STEP_POS  = 2'b01;
   localparam logic [1:0] STEP_ZERO = 2'b00;
   localparam logic [1:0] STEP_NEG  = 2'b11;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

### rtl/blps_front.sv
`timescale 1ns / 1ps
module blps_front #(
   parameter int COORD_BITS = blps_pkg::COORD_BITS_DEFAULT
) (
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_op,
   input  logic signed [COORD_BITS-1:0]  req_x_start,
   input  logic signed [COORD_BITS-1:0]  req_y_start,
   input  logic signed [COORD_BITS-1:0]  req_x_end,
   input  logic signed [COORD_BITS-1:0]  req_y_end,
   input  blps_pkg::queue_status_type    q_status,
   output logic                          q_push,
   output logic [6*COORD_BITS+7:0]       q_entry
);
   import blps_pkg::*;

   localparam int DW = COORD_BITS + 1;

   logic [DW-1:0] diff_x;
   logic [DW-1:0] diff_y;
   logic [DW-1:0] delta_x;
   logic [DW-1:0] delta_y;
   logic [1:0]    step_x;
   logic [1:0]    step_y;
   logic          x_major;

   // take a transfer whenever the queue has room
   assign req_ready = !q_status.full;
   assign q_push    = req_valid && req_ready;

   // absolute deltas, one bit wider than the coordinates
   assign diff_x  = {req_x_end[COORD_BITS-1], req_x_end} - {req_x_start[COORD_BITS-1], req_x_start};
   assign diff_y  = {req_y_end[COORD_BITS-1], req_y_end} - {req_y_start[COORD_BITS-1], req_y_start};
   assign delta_x = diff_x[DW-1] ? (~diff_x + DW'(1)) : diff_x;
   assign delta_y = diff_y[DW-1] ? (~diff_y + DW'(1)) : diff_y;

   // step directions
   always_comb begin
      if (req_x_end > req_x_start) begin
         step_x = STEP_POS;
      end else if (req_x_end == req_x_start) begin
         step_x = STEP_ZERO;
      end else begin
         step_x = STEP_NEG;
      end
      if (req_y_end > req_y_start) begin
         step_y = STEP_POS;
      end else if (req_y_end == req_y_start) begin
         step_y = STEP_ZERO;
      end else begin
         step_y = STEP_NEG;
      end
   end

   // x is the major axis only when strictly longer
   assign x_major = delta_x > delta_y;

   // classified command word
   assign q_entry = {req_op, req_x_start, req_y_start, req_x_end, req_y_end,
                     delta_x, delta_y, step_x, step_y, x_major};

endmodule

### rtl/blps_queue.sv
`timescale 1ns / 1ps
module blps_queue #(
   parameter int WIDTH = 80,
   parameter int DEPTH = blps_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output blps_pkg::queue_status_type status
);
   import blps_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign pop_data     = entry_ff[rd_ptr_ff];

   // pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill count above depth");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("queue popped while empty");
`endif

endmodule

### rtl/blps_back.sv
`timescale 1ns / 1ps
module blps_back #(
   parameter int COORD_BITS = blps_pkg::COORD_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [6*COORD_BITS+7:0]     q_entry,
   input  blps_pkg::queue_status_type  q_status,
   output logic                        q_pop,
   output logic                        pix_valid,
   input  logic                        pix_ready,
   output logic [COORD_BITS-1:0]       pix_x,
   output logic [COORD_BITS-1:0]       pix_y,
   output logic                        pix_last
);
   import blps_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int DW = CB + 1;
   localparam int EW = CB + 4;

   // unpacked command
   logic          e_op;
   logic [CB-1:0] e_x1;
   logic [CB-1:0] e_y1;
   logic [CB-1:0] e_x2;
   logic [CB-1:0] e_y2;
   logic [DW-1:0] e_dx;
   logic [DW-1:0] e_dy;
   logic [1:0]    e_sx;
   logic [1:0]    e_sy;
   logic          e_xmaj;

   // line state
   logic [CB-1:0]        cur_x_ff,   cur_x_in;
   logic [CB-1:0]        cur_y_ff,   cur_y_in;
   logic [CB-1:0]        end_x_ff,   end_x_in;
   logic [CB-1:0]        end_y_ff,   end_y_in;
   logic signed [EW-1:0] err_ff,     err_in;
   logic [DW-1:0]        delta_x_ff, delta_x_in;
   logic [DW-1:0]        delta_y_ff, delta_y_in;
   logic [1:0]           step_x_ff,  step_x_in;
   logic [1:0]           step_y_ff,  step_y_in;
   logic                 x_major_ff, x_major_in;
   logic                 active_ff,  active_in;

   // pixel output register
   logic          pix_valid_ff, pix_valid_in;
   logic [CB-1:0] pix_x_ff,     pix_x_in;
   logic [CB-1:0] pix_y_ff,     pix_y_in;
   logic          pix_last_ff,  pix_last_in;

   // stepping datapath
   logic [DW-1:0]        major_d;
   logic [DW-1:0]        minor_d;
   logic signed [EW-1:0] major_s;
   logic signed [EW-1:0] two_major_s;
   logic signed [EW-1:0] two_minor_s;
   logic signed [EW-1:0] err_sum;
   logic                 minor_step;
   logic [CB-1:0]        inc_x;
   logic [CB-1:0]        inc_y;
   logic [CB-1:0]        next_x;
   logic [CB-1:0]        next_y;
   logic                 free_slot;

   assign {e_op, e_x1, e_y1, e_x2, e_y2, e_dx, e_dy, e_sx, e_sy, e_xmaj} = q_entry;

   // a command runs whenever the pixel register can take its result
   assign free_slot = !pix_valid_ff || pix_ready;
   assign q_pop     = !q_status.empty && free_slot;

   // error test on the current state
   assign major_d     = x_major_ff ? delta_x_ff : delta_y_ff;
   assign minor_d     = x_major_ff ? delta_y_ff : delta_x_ff;
   assign major_s     = signed'({{(EW-DW){1'b0}}, major_d});
   assign two_major_s = signed'({{(EW-DW-1){1'b0}}, major_d, 1'b0});
   assign two_minor_s = signed'({{(EW-DW-1){1'b0}}, minor_d, 1'b0});
   assign err_sum     = err_ff + two_minor_s;
   assign minor_step  = err_sum > major_s;

   assign inc_x  = cur_x_ff + {{(CB-2){step_x_ff[1]}}, step_x_ff};
   assign inc_y  = cur_y_ff + {{(CB-2){step_y_ff[1]}}, step_y_ff};
   assign next_x = (x_major_ff || minor_step) ? inc_x : cur_x_ff;
   assign next_y = (!x_major_ff || minor_step) ? inc_y : cur_y_ff;

   // command execution
   always_comb begin
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      end_x_in     = end_x_ff;
      end_y_in     = end_y_ff;
      err_in       = err_ff;
      delta_x_in   = delta_x_ff;
      delta_y_in   = delta_y_ff;
      step_x_in    = step_x_ff;
      step_y_in    = step_y_ff;
      x_major_in   = x_major_ff;
      active_in    = active_ff;
      pix_valid_in = pix_valid_ff && !pix_ready;
      pix_x_in     = pix_x_ff;
      pix_y_in     = pix_y_ff;
      pix_last_in  = pix_last_ff;
      if (q_pop) begin
         if (e_op == OP_START) begin
            // load a new line and emit its first pixel
            cur_x_in     = e_x1;
            cur_y_in     = e_y1;
            end_x_in     = e_x2;
            end_y_in     = e_y2;
            err_in       = '0;
            delta_x_in   = e_dx;
            delta_y_in   = e_dy;
            step_x_in    = e_sx;
            step_y_in    = e_sy;
            x_major_in   = e_xmaj;
            pix_valid_in = 1'b1;
            pix_x_in     = e_x1;
            pix_y_in     = e_y1;
            pix_last_in  = e_xmaj ? (e_x1 == e_x2) : (e_y1 == e_y2);
            active_in    = !pix_last_in;
         end else if (active_ff) begin
            // one step along the major axis
            cur_x_in     = next_x;
            cur_y_in     = next_y;
            err_in       = minor_step ? (err_sum - two_major_s) : err_sum;
            pix_valid_in = 1'b1;
            pix_x_in     = next_x;
            pix_y_in     = next_y;
            pix_last_in  = x_major_ff ? (next_x == end_x_ff) : (next_y == end_y_ff);
            active_in    = !pix_last_in;
         end else begin
            pix_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         end_x_ff     <= '0;
         end_y_ff     <= '0;
         err_ff       <= '0;
         delta_x_ff   <= '0;
         delta_y_ff   <= '0;
         step_x_ff    <= STEP_ZERO;
         step_y_ff    <= STEP_ZERO;
         x_major_ff   <= 1'b0;
         active_ff    <= 1'b0;
         pix_valid_ff <= 1'b0;
      end else begin
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         end_x_ff     <= end_x_in;
         end_y_ff     <= end_y_in;
         err_ff       <= err_in;
         delta_x_ff   <= delta_x_in;
         delta_y_ff   <= delta_y_in;
         step_x_ff    <= step_x_in;
         step_y_ff    <= step_y_in;
         x_major_ff   <= x_major_in;
         active_ff    <= active_in;
         pix_valid_ff <= pix_valid_in;
      end
   end

   // pixel payload
   always_ff @(posedge clock) begin
      pix_x_ff    <= pix_x_in;
      pix_y_ff    <= pix_y_in;
      pix_last_ff <= pix_last_in;
   end

   assign pix_valid = pix_valid_ff;
   assign pix_x     = pix_x_ff;
   assign pix_y     = pix_y_ff;
   assign pix_last  = pix_last_ff;

`ifndef SYNTHESIS
   a_start_emits: assert property (@(posedge clock) disable iff (reset)
      (q_pop && e_op == OP_START) |=> pix_valid_ff)
      else $error("start command produced no pixel");

   a_idle_advance_silent: assert property (@(posedge clock) disable iff (reset)
      (q_pop && e_op == OP_ADVANCE && !active_ff) |=> !pix_valid_ff)
      else $error("advance with no line produced a pixel");

   a_active_not_at_end: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (x_major_ff ? (cur_x_ff != end_x_ff) : (cur_y_ff != end_y_ff)))
      else $error("line still running at its endpoint");
`endif

endmodule

### rtl/blps_pixel.sv
`timescale 1ns / 1ps
module blps_pixel #(
   parameter int COORD_BITS = blps_pkg::COORD_BITS_DEFAULT,
   parameter int BANK_BITS  = blps_pkg::BANK_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  pix_valid,
   output logic                                  pix_ready,
   input  logic [COORD_BITS-1:0]                 pix_x,
   input  logic [COORD_BITS-1:0]                 pix_y,
   input  logic                                  pix_last,
   input  logic [blps_pkg::DIM_W-1:0]            screen_width,
   input  logic [blps_pkg::DIM_W-1:0]            screen_height,
   input  logic [blps_pkg::COLOR_W-1:0]          draw_color,
   input  logic                                  xor_mode,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [COORD_BITS-1:0]          rsp_pixel_x,
   output logic signed [COORD_BITS-1:0]          rsp_pixel_y,
   output logic                                  rsp_in_bounds,
   output logic [blps_pkg::BANK_FIELD_W-1:0]     rsp_bank,
   output logic [blps_pkg::OFFSET_FIELD_W-1:0]   rsp_bank_offset,
   output logic [blps_pkg::COLOR_W-1:0]          rsp_color,
   output logic                                  rsp_xor_write,
   output logic                                  rsp_last
);
   import blps_pkg::*;

   localparam int CB    = COORD_BITS;
   localparam int CMP_W = CB + DIM_W;
   localparam int LIN_W = CB + DIM_W + 1;
   localparam logic [LIN_W-1:0] OFF_MASK = LIN_W'((64'd1 << BANK_BITS) - 64'd1);

   logic                      inb;
   logic [LIN_W-1:0]          lin;
   logic [LIN_W-1:0]          lin_shift;
   logic [LIN_W-1:0]          lin_masked;
   logic                      load;

   logic                      rsp_valid_ff,  rsp_valid_in;
   logic [CB-1:0]             pixel_x_ff;
   logic [CB-1:0]             pixel_y_ff;
   logic                      in_bounds_ff;
   logic [BANK_FIELD_W-1:0]   bank_ff,   bank_in;
   logic [OFFSET_FIELD_W-1:0] offset_ff, offset_in;
   logic [COLOR_W-1:0]        color_ff;
   logic                      xor_ff;
   logic                      last_ff;

   // output register frees up when empty or being drained
   assign pix_ready = !rsp_valid_ff || rsp_ready;
   assign load      = pix_valid && pix_ready;

   // bounds test: non-negative and below the screen size
   assign inb = !pix_x[CB-1] && !pix_y[CB-1] &&
                (CMP_W'(pix_x) < CMP_W'(screen_width)) &&
                (CMP_W'(pix_y) < CMP_W'(screen_height));

   // linear address y*width + x split into bank and offset
   assign lin        = LIN_W'(pix_y) * LIN_W'(screen_width) + LIN_W'(pix_x);
   assign lin_shift  = lin >> BANK_BITS;
   assign lin_masked = lin & OFF_MASK;
   assign bank_in    = inb ? lin_shift[BANK_FIELD_W-1:0] : '0;
   assign offset_in  = inb ? lin_masked[OFFSET_FIELD_W-1:0] : '0;

   assign rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load) begin
         pixel_x_ff   <= pix_x;
         pixel_y_ff   <= pix_y;
         in_bounds_ff <= inb;
         bank_ff      <= bank_in;
         offset_ff    <= offset_in;
         color_ff     <= draw_color;
         xor_ff       <= xor_mode;
         last_ff      <= pix_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = signed'(pixel_x_ff);
   assign rsp_pixel_y     = signed'(pixel_y_ff);
   assign rsp_in_bounds   = in_bounds_ff;
   assign rsp_bank        = bank_ff;
   assign rsp_bank_offset = offset_ff;
   assign rsp_color       = color_ff;
   assign rsp_xor_write   = xor_ff;
   assign rsp_last        = last_ff;

endmodule

### rtl/bresenham_line_pixel_stepper_top.sv
`timescale 1ns / 1ps
// line pixel stepper: one pixel per accepted start item, and per accepted advance item while a line is in progress
// a result is registered in turn in the queue, the stepper's pixel register and the address stage's result register
// throughput: one item per cycle while results are not back-pressured, bounded by the error update in the stepper
// output register decouples the stepper from result back-pressure; a 2-entry queue decouples input
// reset (synchronous, active high): no line in progress, queue and outputs empty,
// screen 640 x 480, colour 0, overwrite mode
module bresenham_line_pixel_stepper_top #(
   parameter int COORD_BITS = blps_pkg::COORD_BITS_DEFAULT,
   parameter int BANK_BITS  = blps_pkg::BANK_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_op,
   input  logic signed [COORD_BITS-1:0]          req_x_start,
   input  logic signed [COORD_BITS-1:0]          req_y_start,
   input  logic signed [COORD_BITS-1:0]          req_x_end,
   input  logic signed [COORD_BITS-1:0]          req_y_end,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [COORD_BITS-1:0]          rsp_pixel_x,
   output logic signed [COORD_BITS-1:0]          rsp_pixel_y,
   output logic                                  rsp_in_bounds,
   output logic [blps_pkg::BANK_FIELD_W-1:0]     rsp_bank,
   output logic [blps_pkg::OFFSET_FIELD_W-1:0]   rsp_bank_offset,
   output logic [blps_pkg::COLOR_W-1:0]          rsp_color,
   output logic                                  rsp_xor_write,
   output logic                                  rsp_last,
   input  logic                                  csr_wr_en,
   input  logic [blps_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [blps_pkg::CSR_DATA_W-1:0]       csr_wr_data
);
   import blps_pkg::*;

   localparam int ENTRY_W = 6 * COORD_BITS + 8;

   logic [DIM_W-1:0]   width_ff;
   logic [DIM_W-1:0]   height_ff;
   logic [COLOR_W-1:0] color_ff;
   logic               xor_ff;

   queue_status_type   q_status;
   logic               q_push;
   logic               q_pop;
   logic [ENTRY_W-1:0] q_push_data;
   logic [ENTRY_W-1:0] q_pop_data;

   logic                  pix_valid;
   logic                  pix_ready;
   logic [COORD_BITS-1:0] pix_x;
   logic [COORD_BITS-1:0] pix_y;
   logic                  pix_last;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         color_ff  <= '0;
         xor_ff    <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SCREEN_WIDTH: begin
               width_ff <= csr_wr_data[DIM_W-1:0];
            end
            CSR_SCREEN_HEIGHT: begin
               height_ff <= csr_wr_data[DIM_W-1:0];
            end
            CSR_DRAW_COLOR: begin
               color_ff <= csr_wr_data[COLOR_W-1:0];
            end
            CSR_XOR_MODE: begin
               xor_ff <= csr_wr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   // front: accept and classify
   blps_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_op      (req_op),
      .req_x_start (req_x_start),
      .req_y_start (req_y_start),
      .req_x_end   (req_x_end),
      .req_y_end   (req_y_end),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_entry     (q_push_data)
   );

   // command queue
   blps_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   // back: line stepper
   blps_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_entry   (q_pop_data),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .pix_valid (pix_valid),
      .pix_ready (pix_ready),
      .pix_x     (pix_x),
      .pix_y     (pix_y),
      .pix_last  (pix_last)
   );

   // address and bounds stage with result register
   blps_pixel #(
      .COORD_BITS (COORD_BITS),
      .BANK_BITS  (BANK_BITS)
   ) u_pixel (
      .clock           (clock),
      .reset           (reset),
      .pix_valid       (pix_valid),
      .pix_ready       (pix_ready),
      .pix_x           (pix_x),
      .pix_y           (pix_y),
      .pix_last        (pix_last),
      .screen_width    (width_ff),
      .screen_height   (height_ff),
      .draw_color      (color_ff),
      .xor_mode        (xor_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_in_bounds   (rsp_in_bounds),
      .rsp_bank        (rsp_bank),
      .rsp_bank_offset (rsp_bank_offset),
      .rsp_color       (rsp_color),
      .rsp_xor_write   (rsp_xor_write),
      .rsp_last        (rsp_last)
   );

endmodule
